@@ rtl/pmst_pkg.sv @@
// pmst_pkg: field widths and control/status types shared by the prim mst block
// no dependencies

package pmst_pkg;

  localparam int VERTEX_W = 6;   // row, col, child and parent fields
  localparam int WEIGHT_W = 16;  // weight fields on the ports
  localparam int TOTAL_W  = 22;  // running total, wraps
  localparam int VCOUNT_W = 7;   // vertex_count register

  // sequencer to compare unit
  typedef struct packed {
    logic clear;      // start of a relax pass
    logic sample;     // read data valid this cycle
    logic in_tree;    // vertex under test already in the tree
    logic key_valid;  // vertex under test has a finite key
  } pmst_ctl_t;

  // compare unit to sequencer
  typedef struct packed {
    logic upd;    // key and parent of vertex under test improve
    logic found;  // some unvisited vertex with a finite key seen this pass
  } pmst_sts_t;

endpackage

@@ rtl/pmst_if.sv @@
// pmst_if: valid/ready channel interfaces for matrix entries and tree results
// depends on pmst_pkg

interface pmst_in_if;
  logic                           valid;
  logic                           ready;
  logic [pmst_pkg::VERTEX_W-1:0]  row;
  logic [pmst_pkg::VERTEX_W-1:0]  col;
  logic [pmst_pkg::WEIGHT_W-1:0]  weight;
  logic                           last_entry;

  modport source (output valid, output row, output col, output weight,
                  output last_entry, input ready);
  modport sink (input valid, input row, input col, input weight,
                input last_entry, output ready);
endinterface

interface pmst_out_if;
  logic                           valid;
  logic                           ready;
  logic [pmst_pkg::VERTEX_W-1:0]  child_vertex;
  logic [pmst_pkg::VERTEX_W-1:0]  parent_vertex;
  logic [pmst_pkg::WEIGHT_W-1:0]  edge_weight;
  logic                           reached;
  logic [pmst_pkg::TOTAL_W-1:0]   running_total;
  logic                           last_result;

  modport source (output valid, output child_vertex, output parent_vertex,
                  output edge_weight, output reached, output running_total,
                  output last_result, input ready);
  modport sink (input valid, input child_vertex, input parent_vertex,
                input edge_weight, input reached, input running_total,
                input last_result, output ready);
endinterface

@@ rtl/pmst_ram.sv @@
// pmst_ram: generic simple dual port ram, one write and one registered read
// no dependencies

module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pmst_cmp_unit.sv @@
// pmst_cmp_unit: shared relax compare and running minimum search
// depends on pmst_pkg

module pmst_cmp_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pmst_pkg::pmst_ctl_t             ctl,
  input  logic [WEIGHT_BITS-1:0]          edge_w,
  input  logic [WEIGHT_BITS-1:0]          key,
  input  logic [$clog2(MAX_VERTICES)-1:0] vtx,
  output pmst_pkg::pmst_sts_t             sts,
  output logic [$clog2(MAX_VERTICES)-1:0] best
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int KW = WEIGHT_BITS + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  logic [KW-1:0] key_eff;
  logic [KW-1:0] new_key;
  logic [KW-1:0] least;
  logic          cand;
  logic          found;

  // an entry with no valid bit still holds infinity
  assign key_eff = ctl.key_valid ? {1'b0, key} : KEY_INF;
  assign cand    = ctl.sample && (edge_w != '0) && !ctl.in_tree
                   && ({1'b0, edge_w} < key_eff);
  assign new_key = cand ? {1'b0, edge_w} : key_eff;

  // strict less-than over ascending vertices keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      least <= KEY_INF;
      found <= 1'b0;
      best  <= '0;
    end else if (ctl.sample && !ctl.in_tree && (new_key < least)) begin
      least <= new_key;
      found <= 1'b1;
      best  <= vtx[VW-1:0];
    end
  end

  assign sts.upd   = cand;
  assign sts.found = found;

endmodule

@@ rtl/prim_minimum_spanning_tree_core.sv @@
// prim_minimum_spanning_tree_core: prim mst over a streamed adjacency matrix
// depends on pmst_pkg, pmst_if, pmst_ram and pmst_cmp_unit
//
//  channel  | dir | handshake       | beat carries
//  ---------+-----+-----------------+-----------------------------------------
//  in_ch    | in  | valid / ready   | row, col, weight, last_entry
//  out_ch   | out | valid / ready   | child, parent, weight, reached, total, last
//  cfg      | in  | cfg_wr_en       | vertex_count (cfg_wr_data)
//
//  matrix beats are taken one per cycle while the core is idle
//  a last_entry beat with V > 1 starts a run: up to V-1 rounds of a pick,
//    the single relax/min-search pass on the adjacency ram read port, a decide
//  then V-1 result beats, each from two dependent ram reads (key, then adjacency)
//  in_ch.ready stays low from the start of a run until the last result beat
//  out_ch holds its beat while ready is low; sync reset returns to idle

module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pmst_pkg::VCOUNT_W-1:0] cfg_wr_data,
  pmst_in_if.sink                       in_ch,
  pmst_out_if.source                    out_ch
);

  localparam int VW = $clog2(MAX_VERTICES);      // vertex index bits
  localparam int CW = $clog2(MAX_VERTICES + 1);  // vertex count bits
  localparam int AW = 2 * VW;                    // adjacency address bits
  localparam int KD = WEIGHT_BITS + VW;          // key ram word: parent, key

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PICK      = 4'd1;
  localparam logic [3:0] S_RELAX     = 4'd2;
  localparam logic [3:0] S_RELAX_END = 4'd3;
  localparam logic [3:0] S_DECIDE    = 4'd4;
  localparam logic [3:0] S_OUT_KEY   = 4'd5;
  localparam logic [3:0] S_OUT_ADJ   = 4'd6;
  localparam logic [3:0] S_OUT_CALC  = 4'd7;
  localparam logic [3:0] S_OUT_HOLD  = 4'd8;

  logic [3:0]                  state;
  logic [pmst_pkg::VCOUNT_W-1:0] vcount;
  logic [CW-1:0]               n_vtx;

  logic [MAX_VERTICES-1:0]     in_tree;
  logic [MAX_VERTICES-1:0]     key_valid;
  logic [VW-1:0]               u;        // vertex picked this round
  logic [CW-1:0]               picks;
  logic [CW-1:0]               v;        // relax pass issue counter
  logic [VW-1:0]               v_d;      // vertex whose read data is back
  logic                        rd_vld;
  logic [CW-1:0]               i;        // result counter
  logic [VW-1:0]               par_r;
  logic                        reached_r;
  logic [pmst_pkg::TOTAL_W-1:0] cost_sum;

  // result register
  logic                          out_valid;
  logic [pmst_pkg::VERTEX_W-1:0] out_child;
  logic [pmst_pkg::VERTEX_W-1:0] out_parent;
  logic [pmst_pkg::WEIGHT_W-1:0] out_weight;
  logic                          out_reached;
  logic [pmst_pkg::TOTAL_W-1:0]  out_total;
  logic                          out_last;

  // ram ports
  logic                   adj_we;
  logic [AW-1:0]          adj_waddr;
  logic [WEIGHT_BITS-1:0] adj_wdata;
  logic [AW-1:0]          adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_rdata;
  logic                   key_we;
  logic [KD-1:0]          key_wdata;
  logic [VW-1:0]          key_raddr;
  logic [KD-1:0]          key_rdata;

  pmst_pkg::pmst_ctl_t    ctl;
  pmst_pkg::pmst_sts_t    sts;
  logic [VW-1:0]          best;

  logic                   in_acc;
  logic                   in_range;
  logic [VW-1:0]          rd_par;
  logic [WEIGHT_BITS-1:0] res_w;
  logic [pmst_pkg::TOTAL_W-1:0] cost_next;

  // vertex count in use: zero acts as one, clamp at the store size
  always_comb begin
    if (vcount == '0) begin
      n_vtx = CW'(1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      n_vtx = CW'(MAX_VERTICES);
    end else begin
      n_vtx = CW'(vcount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= pmst_pkg::VCOUNT_W'(64);
    end else if (cfg_wr_en) begin
      vcount <= cfg_wr_data;
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.row) < MAX_VERTICES)
                       && (int'(in_ch.col) < MAX_VERTICES);

  // adjacency store, row-major with a power of two row stride
  assign adj_we    = in_acc && in_range;
  assign adj_waddr = {VW'(in_ch.row), VW'(in_ch.col)};
  assign adj_wdata = WEIGHT_BITS'(in_ch.weight);
  assign rd_par    = key_valid[i[VW-1:0]] ? key_rdata[KD-1 -: VW] : '0;
  assign adj_raddr = (state == S_OUT_ADJ) ? {i[VW-1:0], rd_par} : {u, v[VW-1:0]};

  pmst_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (1 << AW)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // key and parent per vertex; key_valid marks entries with a finite key
  assign key_we    = sts.upd;
  assign key_wdata = {u, adj_rdata};
  assign key_raddr = (state == S_OUT_KEY) ? i[VW-1:0] : v[VW-1:0];

  pmst_ram #(
    .WIDTH (KD),
    .DEPTH (MAX_VERTICES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (v_d),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // one compare unit does relaxation and next-vertex search in the same pass
  assign ctl.clear     = (state == S_PICK);
  assign ctl.sample    = rd_vld;
  assign ctl.in_tree   = in_tree[v_d];
  assign ctl.key_valid = key_valid[v_d];

  pmst_cmp_unit #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_cmp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .edge_w (adj_rdata),
    .key    (key_rdata[WEIGHT_BITS-1:0]),
    .vtx    (v_d),
    .sts    (sts),
    .best   (best)
  );

  // unreached vertices report weight zero
  assign res_w     = reached_r ? adj_rdata : '0;
  assign cost_next = cost_sum + pmst_pkg::TOTAL_W'(res_w);

  // read data stage of the relax pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_RELAX);
    end
    v_d <= v[VW-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_tree   <= '0;
      key_valid <= '0;
      u         <= '0;
      picks     <= '0;
      v         <= '0;
      i         <= '0;
      cost_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (sts.upd) begin
        key_valid[v_d] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && in_ch.last_entry && (n_vtx > CW'(1))) begin
            in_tree   <= '0;
            key_valid <= '0;
            u         <= '0;
            picks     <= '0;
            cost_sum  <= '0;
            state     <= S_PICK;
          end
        end
        S_PICK: begin
          in_tree[u] <= 1'b1;
          picks      <= picks + CW'(1);
          v          <= '0;
          state      <= S_RELAX;
        end
        S_RELAX: begin
          v <= v + CW'(1);
          if (v == n_vtx - CW'(1)) begin
            state <= S_RELAX_END;
          end
        end
        S_RELAX_END: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if ((picks == n_vtx - CW'(1)) || !sts.found) begin
            i     <= CW'(1);
            state <= S_OUT_KEY;
          end else begin
            u     <= best;
            state <= S_PICK;
          end
        end
        S_OUT_KEY: begin
          state <= S_OUT_ADJ;
        end
        S_OUT_ADJ: begin
          par_r     <= rd_par;
          reached_r <= key_valid[i[VW-1:0]];
          state     <= S_OUT_CALC;
        end
        S_OUT_CALC: begin
          cost_sum    <= cost_next;
          out_child   <= pmst_pkg::VERTEX_W'(i);
          out_parent  <= pmst_pkg::VERTEX_W'(par_r);
          out_weight  <= pmst_pkg::WEIGHT_W'(res_w);
          out_reached <= reached_r;
          out_total   <= cost_next;
          out_last    <= (i == n_vtx - CW'(1));
          out_valid   <= 1'b1;
          state       <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (i == n_vtx - CW'(1)) begin
              state <= S_IDLE;
            end else begin
              i     <= i + CW'(1);
              state <= S_OUT_KEY;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.child_vertex  = out_child;
  assign out_ch.parent_vertex = out_parent;
  assign out_ch.edge_weight   = out_weight;
  assign out_ch.reached       = out_reached;
  assign out_ch.running_total = out_total;
  assign out_ch.last_result   = out_last;

endmodule

@@ rtl/pmst_checker.sv @@
// pmst_checker: port-level assertions for the prim mst core, bound to the top
// depends on pmst_pkg and prim_minimum_spanning_tree_core

module pmst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pmst_pkg::VERTEX_W-1:0] out_child,
  input logic [pmst_pkg::TOTAL_W-1:0]  out_total,
  input logic                          out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_child)
                                   && $stable(out_total)))
    else $error("result beat changed while stalled");

  // no matrix beat is taken while results are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // a plain matrix entry leaves the core idle
  a_plain_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_last) |=> in_ready)
    else $error("core left idle after a non-final entry");

  // the final result of a run ends the output stream
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result beat after the last result");

  // vertex zero is the root and never reported
  a_child_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_child != '0))
    else $error("root vertex reported as a child");

endmodule

bind prim_minimum_spanning_tree_core pmst_checker u_pmst_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_entry),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_child (out_ch.child_vertex),
  .out_total (out_ch.running_total),
  .out_last  (out_ch.last_result)
);
